// ===== hw/rtl/bcm_pkg.sv =====
// Package for the battery cutoff monitor: action codes, register indexes
// and register reset values.
// Depends on nothing; used by battery_cutoff_monitor.
package bcm_pkg;

  // Action codes carried by a result transaction.
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_DISABLE = 2'd1;
  localparam logic [1:0] ACT_ENABLE  = 2'd2;
  localparam logic [1:0] ACT_SHIP    = 2'd3;

  // Register file geometry: seven 32-bit words at byte addresses 4*i.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WARNING_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_CONFIRM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_CONFIRM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLAUSIBLE_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLAUSIBLE_HIGH   = 3'd6;

  // Reset values of the registers, in millivolts or samples.
  localparam logic [15:0] RST_WARNING_LEVEL    = 16'd3300;
  localparam logic [15:0] RST_RECOVERY_LEVEL   = 16'd3500;
  localparam logic [15:0] RST_CRITICAL_LEVEL   = 16'd3000;
  localparam logic [7:0]  RST_WARNING_CONFIRM  = 8'd3;
  localparam logic [7:0]  RST_CRITICAL_CONFIRM = 8'd3;
  localparam logic [15:0] RST_PLAUSIBLE_LOW    = 16'd2000;
  localparam logic [15:0] RST_PLAUSIBLE_HIGH   = 16'd4500;

endpackage

// ===== hw/rtl/battery_cutoff_monitor.sv =====
// Battery cutoff monitor top level: sample stream in, action stream out,
// APB-style register port for thresholds and confirm counts.
// Depends on bcm_pkg.
//
// Channel   Direction  Signals                       Transaction contents
// s_*       in         s_tvalid s_tready s_tdata     sample_mv, external_power
// m_*       out        m_tvalid m_tready m_tdata     action
// APB       in/out     psel penable pwrite paddr ... register write or read
//
// Every accepted sample gives exactly one registered action, so one sample
// can be taken in every clock cycle while the skid register is free. The
// decision is a handful of 16-bit compares and two 8-bit counter updates
// between the input bus and the result register. A two-entry output stage
// (result register plus skid register) lets one further sample be taken
// while a result is stalled. Reset (rst, synchronous) clears the warning,
// both counters and the output stage, and restores the register reset values.
module battery_cutoff_monitor (
  input  logic                          clk,
  input  logic                          rst,
  // Sample stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // [15:0] sample_mv, [16] external_power
  // Action stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [1:0] action
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [15:0] warning_level;
  logic [15:0] recovery_level;
  logic [15:0] critical_level;
  logic [7:0]  warning_confirm;
  logic [7:0]  critical_confirm;
  logic [15:0] plausible_low;
  logic [15:0] plausible_high;

  logic                           cfg_write;
  logic [bcm_pkg::CFG_IDX_W-1:0]  cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // Word index; the two byte-offset bits are not decoded.
  assign cfg_idx   = paddr[bcm_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      warning_level    <= bcm_pkg::RST_WARNING_LEVEL;
      recovery_level   <= bcm_pkg::RST_RECOVERY_LEVEL;
      critical_level   <= bcm_pkg::RST_CRITICAL_LEVEL;
      warning_confirm  <= bcm_pkg::RST_WARNING_CONFIRM;
      critical_confirm <= bcm_pkg::RST_CRITICAL_CONFIRM;
      plausible_low    <= bcm_pkg::RST_PLAUSIBLE_LOW;
      plausible_high   <= bcm_pkg::RST_PLAUSIBLE_HIGH;
    end else if (cfg_write) begin
      case (cfg_idx)
        bcm_pkg::REG_WARNING_LEVEL:    warning_level    <= pwdata[15:0];
        bcm_pkg::REG_RECOVERY_LEVEL:   recovery_level   <= pwdata[15:0];
        bcm_pkg::REG_CRITICAL_LEVEL:   critical_level   <= pwdata[15:0];
        bcm_pkg::REG_WARNING_CONFIRM:  warning_confirm  <= pwdata[7:0];
        bcm_pkg::REG_CRITICAL_CONFIRM: critical_confirm <= pwdata[7:0];
        bcm_pkg::REG_PLAUSIBLE_LOW:    plausible_low    <= pwdata[15:0];
        bcm_pkg::REG_PLAUSIBLE_HIGH:   plausible_high   <= pwdata[15:0];
        default: begin
          // Writes to the unused word are dropped.
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bcm_pkg::REG_WARNING_LEVEL:    prdata = {16'd0, warning_level};
      bcm_pkg::REG_RECOVERY_LEVEL:   prdata = {16'd0, recovery_level};
      bcm_pkg::REG_CRITICAL_LEVEL:   prdata = {16'd0, critical_level};
      bcm_pkg::REG_WARNING_CONFIRM:  prdata = {24'd0, warning_confirm};
      bcm_pkg::REG_CRITICAL_CONFIRM: prdata = {24'd0, critical_confirm};
      bcm_pkg::REG_PLAUSIBLE_LOW:    prdata = {16'd0, plausible_low};
      bcm_pkg::REG_PLAUSIBLE_HIGH:   prdata = {16'd0, plausible_high};
      default:                       prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Decision logic. It works straight from the input bus and the held
  // state, and its result lands in the output stage at the same edge at
  // which the state is updated.
  // ---------------------------------------------------------------------
  logic        warning_on;
  logic [7:0]  low_count;
  logic [7:0]  critical_count;
  logic        warning_on_next;
  logic [7:0]  low_count_next;
  logic [7:0]  critical_count_next;
  logic [1:0]  action_next;

  logic [15:0] sample_mv;
  logic        external_power;
  logic        in_fire;
  logic        out_fire;
  logic        plausible;
  logic        is_low;
  logic        is_critical;
  logic [7:0]  low_inc;
  logic [7:0]  crit_inc;

  assign sample_mv      = s_tdata[15:0];
  assign external_power = s_tdata[16];
  assign in_fire        = s_tvalid && s_tready;
  assign out_fire       = m_tvalid && m_tready;

  // An inverted window makes every sample implausible, which these two
  // compares give without any special handling.
  assign plausible   = (sample_mv >= plausible_low) && (sample_mv <= plausible_high);
  assign is_low      = (sample_mv <= warning_level);
  assign is_critical = (sample_mv <= critical_level);

  // Saturating increments. A count already at or above its confirm value
  // (for instance after the confirm value was lowered) is held, so the
  // increment can never wrap.
  assign low_inc  = (low_count < warning_confirm) ? low_count + 8'd1 : low_count;
  assign crit_inc = (critical_count < critical_confirm) ? critical_count + 8'd1
                                                        : critical_count;

  always_comb begin
    warning_on_next     = warning_on;
    low_count_next      = low_count;
    critical_count_next = critical_count;
    action_next         = bcm_pkg::ACT_NONE;

    if (external_power) begin
      // On external supply everything clears and no action is taken.
      warning_on_next     = 1'b0;
      low_count_next      = 8'd0;
      critical_count_next = 8'd0;
    end else if (!plausible) begin
      // A reading outside the window breaks both runs but keeps the warning.
      low_count_next      = 8'd0;
      critical_count_next = 8'd0;
    end else begin
      if (is_low) begin
        if (!warning_on) begin
          low_count_next = low_inc;
          if (low_inc >= warning_confirm) begin
            warning_on_next = 1'b1;
            action_next     = bcm_pkg::ACT_DISABLE;
          end
        end
      end else begin
        low_count_next = 8'd0;
        if (warning_on && (sample_mv >= recovery_level)) begin
          warning_on_next = 1'b0;
          action_next     = bcm_pkg::ACT_ENABLE;
        end
      end

      // Ship mode overrides the warning action but not its state change.
      if (is_critical) begin
        critical_count_next = crit_inc;
        if (crit_inc >= critical_confirm) begin
          action_next = bcm_pkg::ACT_SHIP;
        end
      end else begin
        critical_count_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warning_on     <= 1'b0;
      low_count      <= 8'd0;
      critical_count <= 8'd0;
    end else if (in_fire) begin
      warning_on     <= warning_on_next;
      low_count      <= low_count_next;
      critical_count <= critical_count_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: result register plus one skid register. The input side
  // is ready whenever the skid register is free, so a stalled result does
  // not stop the next sample from being taken.
  // ---------------------------------------------------------------------
  logic        out_valid;
  logic [1:0]  out_action;
  logic        skid_valid;
  logic [1:0]  skid_action;

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_action};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_fire || !out_valid) begin
        // The result register is free: refill from the skid register first,
        // else from a new transaction.
        out_valid  <= skid_valid || in_fire;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      out_action <= skid_valid ? skid_action : action_next;
    end
    if (in_fire && out_valid && !out_fire) begin
      skid_action <= action_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_skid_implies_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the result register is empty");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> (m_tvalid && !skid_valid))
    else $error("skid register did not move into the result register");

  a_ext_clears : assert property (@(posedge clk) disable iff (rst)
    (in_fire && external_power) |=>
      (!warning_on && (low_count == 8'd0) && (critical_count == 8'd0)))
    else $error("external power did not clear the monitor state");

  a_implausible_clears : assert property (@(posedge clk) disable iff (rst)
    (in_fire && !external_power && !plausible) |=>
      ((low_count == 8'd0) && (critical_count == 8'd0) && $stable(warning_on)))
    else $error("implausible sample did not clear the counters");

endmodule
